// File: rtl/exchange_sort_records_by_key_core_assert.svh
// Assertion macros for the exchange sort core.
`ifndef EXCHANGE_SORT_RECORDS_BY_KEY_CORE_ASSERT_SVH
`define EXCHANGE_SORT_RECORDS_BY_KEY_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ESRK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESRK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esrk_pkg.sv
// Package: types and constants of the exchange sort core.
`default_nettype none

package esrk_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_W           = 16;
  localparam int TAG_W           = 16;
  localparam int REC_W           = KEY_W + TAG_W;

  typedef struct packed {
    logic [KEY_W-1:0] score_key;
    logic [TAG_W-1:0] record_tag;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             last_result;
    logic             overflowed;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } record_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_SORT_J,
    ST_SORT_WB,
    ST_EMIT_RD,
    ST_EMIT_WT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/exchange_sort_records_by_key_core.sv
// Top level: loads keyed records, exchange-sorts them in RAM, emits them in order.
//
//  channel | ports                       | direction | payload
//  --------+-----------------------------+-----------+------------------------
//  input   | in_valid, in_stall, in_data | in        | esrk_pkg::in_item_t
//  result  | out_valid, out_stall, out_data | out    | esrk_pkg::out_item_t
//
//  Loading accepts one record per cycle; in_stall is low only while loading.
//  Sort: for each position i, the later records are read one per cycle on the
//  single read port, with the current record i held in a register.
//  Emit reads each result from RAM, then loads it into the output register when free.
//  A new set is accepted once the last result sits in the output register.
//  Synchronous active-low reset clears control state; RAM contents stay undefined.
`default_nettype none

module exchange_sort_records_by_key_core #(
  parameter int MAX_RECORDS = esrk_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire esrk_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output esrk_pkg::out_item_t      out_data
);

  `include "exchange_sort_records_by_key_core_assert.svh"

  localparam int AW    = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  esrk_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                rd_is_i_r, rd_is_i_nxt;
  esrk_pkg::record_t   cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  esrk_pkg::out_item_t out_data_r, out_data_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  esrk_pkg::record_t   ram_wdata, rd_rec;

  logic                in_fire;
  logic                out_free;

  esrk_ram #(
    .WIDTH (esrk_pkg::REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_rec)
  );

  assign in_stall  = (state_r != esrk_pkg::ST_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esrk_pkg::ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_is_i_r  <= rd_is_i_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rd_idx_nxt    = rd_idx_r;
    rd_is_i_nxt   = rd_is_i_r;
    cur_nxt       = cur_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_raddr     = j_r[AW-1:0];
    ram_wdata     = cur_r;

    unique case (state_r)
      esrk_pkg::ST_LOAD: begin
        ram_waddr = count_r[AW-1:0];
        ram_wdata = '{key: in_data.score_key, tag: in_data.record_tag};
        if (in_fire) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            i_nxt     = '0;
            state_nxt = (count_nxt < CNT_W'(2)) ? esrk_pkg::ST_EMIT_RD
                                                : esrk_pkg::ST_SORT_I;
          end
        end
      end

      esrk_pkg::ST_SORT_I: begin
        ram_re      = 1'b1;
        ram_raddr   = i_r[AW-1:0];
        j_nxt       = i_r + CNT_W'(1);
        rd_is_i_nxt = 1'b1;
        state_nxt   = esrk_pkg::ST_SORT_J;
      end

      esrk_pkg::ST_SORT_J: begin
        // rd_rec holds record i on the first pass, else record rd_idx_r
        if (rd_is_i_r) begin
          cur_nxt = rd_rec;
        end else if (cur_r.key > rd_rec.key) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r;
          ram_wdata = cur_r;
          cur_nxt   = rd_rec;
        end
        if (j_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = j_r[AW-1:0];
          rd_idx_nxt  = j_r[AW-1:0];
          rd_is_i_nxt = 1'b0;
          j_nxt       = j_r + CNT_W'(1);
        end else begin
          state_nxt = esrk_pkg::ST_SORT_WB;
        end
      end

      esrk_pkg::ST_SORT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = cur_r;
        if (({1'b0, i_r} + (CNT_W+1)'(2)) >= {1'b0, count_r}) begin
          i_nxt     = '0;
          state_nxt = esrk_pkg::ST_EMIT_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = esrk_pkg::ST_SORT_I;
        end
      end

      esrk_pkg::ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = i_r[AW-1:0];
        state_nxt = esrk_pkg::ST_EMIT_WT;
      end

      esrk_pkg::ST_EMIT_WT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sorted_key:  rd_rec.key,
                            sorted_tag:  rd_rec.tag,
                            last_result: (i_r + CNT_W'(1) == count_r),
                            overflowed:  ovf_r};
          if (i_r + CNT_W'(1) == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = esrk_pkg::ST_LOAD;
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = esrk_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = esrk_pkg::ST_LOAD;
      end
    endcase
  end

  `ESRK_ASSERT_SAME(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr,
    "RAM read and write hit the same entry")
  `ESRK_ASSERT_SAME(a_emit_in_range, state_r == esrk_pkg::ST_EMIT_RD, i_r < count_r,
    "emit index beyond stored records")
  `ESRK_ASSERT_SAME(a_j_after_i, (state_r == esrk_pkg::ST_SORT_J) && !rd_is_i_r,
    {1'b0, rd_idx_r} > i_r, "compare partner not after current position")
  `ESRK_ASSERT_NEXT(a_out_from_emit, !out_valid_r || !out_stall,
    !out_valid_r || $past(state_r == esrk_pkg::ST_EMIT_WT),
    "result loaded outside emit")

endmodule

`default_nettype wire

// File: rtl/esrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module esrk_ram #(
  parameter int WIDTH = esrk_pkg::REC_W,
  parameter int DEPTH = esrk_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: tb/exchange_sort_records_by_key_core_tb.sv
// Testbench for exchange_sort_records_by_key_core: directed and random record sets, self-checked.
`timescale 1ns / 100ps

module exchange_sort_records_by_key_core_tb;

  localparam int CAP          = esrk_pkg::MAX_RECORDS_DEF;
  localparam int TARGET_ITEMS = 380;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 30;
  localparam int SETTLE       = 50;

  typedef enum int {KEYS_SPREAD, KEYS_TIED, KEYS_EDGE} key_mix_t;

  typedef struct {
    esrk_pkg::in_item_t item;
    int unsigned        gap;
    bit                 drain;
  } feed_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  esrk_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  esrk_pkg::out_item_t out_data;

  feed_t               feed_q[$];
  esrk_pkg::out_item_t sorted_q[$];
  logic [15:0]         key_mem[CAP];
  logic [15:0]         tag_mem[CAP];
  int                  fill_cnt;
  bit                  lost_flag;

  int          mismatch_count;
  int          sent_count;
  int          got_count;
  int          set_count;
  int          lost_sets;
  int unsigned cycle_count;

  int unsigned wait_cnt;
  int unsigned rx_gap;
  int unsigned hold_left;
  bit          rx_calm;

  exchange_sort_records_by_key_core #(.MAX_RECORDS(CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] key_for(key_mix_t mix);
    case (mix)
      KEYS_TIED: begin
        return 16'($urandom_range(0, 3));
      end
      KEYS_EDGE: begin
        case ($urandom_range(0, 2))
          0: return 16'h0000;
          1: return 16'hFFFF;
          default: return 16'($urandom_range(0, 65535));
        endcase
      end
      default: begin
        return 16'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic add_item(logic [15:0] key, logic [15:0] tag, logic last,
                          int unsigned gap, bit drain);
    feed_t f;
    f.item.score_key  = key;
    f.item.record_tag = tag;
    f.item.last_item  = last;
    f.gap             = gap;
    f.drain           = drain;
    feed_q.push_back(f);
  endtask

  // Stores one record while room is left; on the last mark, sorts and queues the whole set.
  task automatic store_and_sort(esrk_pkg::in_item_t rec);
    logic [15:0]         k;
    logic [15:0]         t;
    esrk_pkg::out_item_t r;
    if (fill_cnt < CAP) begin
      key_mem[fill_cnt] = rec.score_key;
      tag_mem[fill_cnt] = rec.record_tag;
      fill_cnt++;
    end else begin
      lost_flag = 1'b1;
    end
    if (rec.last_item) begin
      for (int i = 0; i < fill_cnt; i++) begin
        for (int j = i + 1; j < fill_cnt; j++) begin
          if (key_mem[i] > key_mem[j]) begin
            k = key_mem[i];
            t = tag_mem[i];
            key_mem[i] = key_mem[j];
            tag_mem[i] = tag_mem[j];
            key_mem[j] = k;
            tag_mem[j] = t;
          end
        end
      end
      for (int n = 0; n < fill_cnt; n++) begin
        r.sorted_key  = key_mem[n];
        r.sorted_tag  = tag_mem[n];
        r.last_result = (n == fill_cnt - 1);
        r.overflowed  = lost_flag;
        sorted_q.push_back(r);
      end
      set_count++;
      if (lost_flag) begin
        lost_sets++;
      end
      fill_cnt  = 0;
      lost_flag = 1'b0;
    end
  endtask

  always @(posedge clk) begin : tx
    logic fire;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_cnt = 0;
    end else begin
      if (fire) begin
        store_and_sort(in_data);
        sent_count++;
      end
      if (!in_valid || fire) begin
        if (feed_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (feed_q[0].drain && sorted_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (wait_cnt < feed_q[0].gap) begin
          wait_cnt++;
          in_valid <= 1'b0;
        end else begin
          in_data  <= feed_q[0].item;
          in_valid <= 1'b1;
          feed_q.pop_front();
          wait_cnt = 0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx
    esrk_pkg::out_item_t want;
    logic                stall_nx;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
      rx_calm   = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: key %h tag %h", out_data.sorted_key, out_data.sorted_tag);
          mismatch_count++;
        end else begin
          want = sorted_q.pop_front();
          if (out_data.sorted_key !== want.sorted_key) begin
            $error("sorted_key: expected %h, actual %h", want.sorted_key, out_data.sorted_key);
            mismatch_count++;
          end
          if (out_data.sorted_tag !== want.sorted_tag) begin
            $error("sorted_tag: expected %h, actual %h", want.sorted_tag, out_data.sorted_tag);
            mismatch_count++;
          end
          if (out_data.last_result !== want.last_result) begin
            $error("last_result: expected %b, actual %b", want.last_result,
                   out_data.last_result);
            mismatch_count++;
          end
          if (out_data.overflowed !== want.overflowed) begin
            $error("overflowed: expected %b, actual %b", want.overflowed, out_data.overflowed);
            mismatch_count++;
          end
        end
        got_count++;
        // long back-pressure: block holds in emit and stalls its input
        if (got_count == HOLD_AT) begin
          hold_left = LONG_HOLD;
        end
        if (got_count % 64 == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nx = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        stall_nx = 1'b1;
      end else begin
        stall_nx = 1'b0;
        if (!rx_calm) begin
          rx_gap = pick_gap();
        end
      end
      out_stall <= stall_nx;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : main
    int       total;
    int       set_idx;
    int       n;
    key_mix_t mix;
    bit       calm;
    bit       drain;

    // single records at both extremes
    add_item(16'hFFFF, 16'hFFFF, 1'b1, 0, 1'b1);
    add_item(16'h0000, 16'h0000, 1'b1, 0, 1'b1);
    // one swap
    add_item(16'hFFFF, 16'h0001, 1'b0, 0, 1'b1);
    add_item(16'h0000, 16'h0002, 1'b1, 0, 1'b0);
    // equal keys
    add_item(16'h0005, 16'h000A, 1'b0, 0, 1'b1);
    add_item(16'h0005, 16'h000B, 1'b0, 0, 1'b0);
    add_item(16'h0003, 16'h000C, 1'b0, 0, 1'b0);
    add_item(16'h0005, 16'h000D, 1'b0, 0, 1'b0);
    add_item(16'h0003, 16'h000E, 1'b1, 0, 1'b0);
    // reverse order
    for (int k = 0; k < 8; k++) begin
      add_item(16'hFF00 - 16'(k * 16'h1FE0), 16'(k), (k == 7), 0, (k == 0));
    end
    // alternating bit patterns
    add_item(16'hAAAA, 16'h5555, 1'b0, 0, 1'b1);
    add_item(16'h5555, 16'hAAAA, 1'b0, 0, 1'b0);
    add_item(16'hAAAA, 16'hAAAA, 1'b0, 0, 1'b0);
    add_item(16'h5555, 16'h5555, 1'b1, 0, 1'b0);

    total   = feed_q.size();
    set_idx = 0;
    while (total < TARGET_ITEMS) begin
      case (set_idx)
        2: n = CAP;
        5: n = CAP + 1;
        9: n = CAP + 6;
        default: n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                 : $urandom_range(1, 12);
      endcase
      mix   = key_mix_t'($urandom_range(0, 2));
      calm  = ($urandom_range(0, 4) == 0);
      // sets around the long hold keep the sender offering
      drain = (set_idx == 0) || ((set_idx > 3) && ($urandom_range(0, 5) == 0));
      for (int k = 0; k < n; k++) begin
        add_item(key_for(mix), 16'($urandom_range(0, 65535)), (k == n - 1),
                 calm ? 0 : pick_gap(), drain && (k == 0));
      end
      total += n;
      set_idx++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_valid) @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d records sent in %0d sets (%0d with dropped records), %0d results checked",
             sent_count, set_count, lost_sets, got_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/esrk_pkg.sv
rtl/esrk_ram.sv
rtl/exchange_sort_records_by_key_core.sv
tb/exchange_sort_records_by_key_core_tb.sv
